// ===== rtl/fci_pkg.sv =====
// shared types, widths and codes of the fan curve interpolator
`timescale 1ns / 1ps

package fci_pkg;

  // field widths
  localparam int TEMP_W   = 8;
  localparam int SPEED_W  = 7;
  localparam int INDEX_W  = 4;
  localparam int PIU_W    = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  // magnitude widths of the interpolation arithmetic
  localparam int PROD_W = 15;
  localparam int DX_W   = 8;

  localparam int MAX_POINTS_DEF = 16;

  // request kinds carried on in_tuser
  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_t;

  // one curve point as held in the point memory
  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [TEMP_W-1:0]  temp;
  } point_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_SCAN,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_DONE
  } state_t;

  // which endpoint pair the interpolation uses
  typedef enum logic {
    PAIR_CUR,
    PAIR_SAVED
  } pair_sel_t;

  // source of the result register
  typedef enum logic [1:0] {
    RES_RDATA,
    RES_Y1,
    RES_QUOT
  } res_sel_t;

  typedef struct packed {
    logic      wr_en;
    logic      capture_t;
    logic      load_prev;
    logic      save_first;
    logic      set_pair;
    pair_sel_t pair_sel;
    logic      mul_load;
    logic      div_start;
    logic      res_load;
    res_sel_t  res_sel;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic none;
    logic idx_ok;
    logic t_ge_rd;
    logic t_le_rd;
    logic in_interval;
    logic dx_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/fci_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module fci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fci_div.sv =====
// restoring divider for the interpolation quotient, one bit per cycle
`timescale 1ns / 1ps

module fci_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fci_pkg::PROD_W-1:0] num,
  input  logic [fci_pkg::DX_W-1:0]   den,
  output logic                       done,
  output logic [fci_pkg::PROD_W-1:0] quot
);
  import fci_pkg::*;

  localparam int STEP_W = $clog2(PROD_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DX_W-1:0]   rem_r;
  logic [DX_W-1:0]   den_r;
  logic [PROD_W-1:0] quo_r;

  logic [DX_W:0]     shifted;
  logic [DX_W+1:0]   diff;
  logic              fits;

  // trial subtraction of one quotient bit
  always_comb begin
    shifted = {rem_r, quo_r[PROD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    fits    = ~diff[DX_W+1];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DX_W-1:0] : shifted[DX_W-1:0];
      quo_r <= {quo_r[PROD_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/fci_datapath.sv =====
// curve memory, interval registers, interpolation arithmetic and output register
`timescale 1ns / 1ps

module fci_datapath #(
  parameter int MAX_POINTS = fci_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_valid,
  input  logic [fci_pkg::PIU_W-1:0]        cfg_data,
  // request fields
  input  logic [fci_pkg::INDEX_W-1:0]      point_index,
  input  logic [fci_pkg::TEMP_W-1:0]       point_temp,
  input  logic [fci_pkg::SPEED_W-1:0]      point_speed,
  input  logic [fci_pkg::TEMP_W-1:0]       sample_temp,
  // controller link
  input  fci_pkg::ctrl_cmd_t               cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]    rd_addr,
  output logic [$clog2(MAX_POINTS)-1:0]    last_addr,
  output fci_pkg::dp_status_t              status,
  // result
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [fci_pkg::SPEED_W-1:0]      fan_speed
);
  import fci_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  logic [PIU_W-1:0]   pts_r;
  logic [CNT_W-1:0]   used;
  logic [TEMP_W-1:0]  t_r;
  point_t             rd_point;
  logic [$bits(point_t)-1:0] rd_data;
  point_t             prev_r;
  point_t             first_lo_r;
  point_t             first_hi_r;
  point_t             lo_r;
  point_t             hi_r;

  logic signed [8:0]  dx;
  logic signed [7:0]  dy;
  logic signed [8:0]  dt;
  logic signed [16:0] prod;
  logic [16:0]        prod_abs;
  logic [8:0]         dx_abs;
  logic [PROD_W-1:0]  prod_mag_r;
  logic               prod_neg_r;
  logic [DX_W-1:0]    dx_mag_r;
  logic               dx_neg_r;

  logic [PROD_W-1:0]  quot;
  logic               div_done;
  logic signed [16:0] q_s;
  logic signed [16:0] v;
  logic [SPEED_W-1:0] v_sat;
  logic [SPEED_W-1:0] res_nxt;
  logic [SPEED_W-1:0] res_r;
  logic               out_valid_r;
  logic [SPEED_W-1:0] out_speed_r;

  // points in use, limited to the memory depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r <= '0;
    end else if (cfg_valid) begin
      pts_r <= cfg_data;
    end
  end

  always_comb begin
    if (32'(pts_r) > MAX_POINTS) begin
      used = CNT_W'(MAX_POINTS);
    end else begin
      used = CNT_W'(pts_r);
    end
  end

  assign last_addr = ADDR_W'(used - 1'b1);

  // curve point memory
  fci_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_points (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (ADDR_W'(point_index)),
    .wr_data ({point_speed, point_temp}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_point = point_t'(rd_data);

  // sample and interval registers
  always_ff @(posedge clk) begin
    if (cmd.capture_t) begin
      t_r <= sample_temp;
    end
    if (cmd.load_prev) begin
      prev_r <= rd_point;
    end
    if (cmd.save_first) begin
      first_lo_r <= prev_r;
      first_hi_r <= rd_point;
    end
    if (cmd.set_pair) begin
      if (cmd.pair_sel == PAIR_SAVED) begin
        lo_r <= first_lo_r;
        hi_r <= first_hi_r;
      end else begin
        lo_r <= prev_r;
        hi_r <= rd_point;
      end
    end
  end

  // slope terms and product
  always_comb begin
    dx       = $signed({1'b0, hi_r.temp}) - $signed({1'b0, lo_r.temp});
    dy       = $signed({1'b0, hi_r.speed}) - $signed({1'b0, lo_r.speed});
    dt       = $signed({1'b0, t_r}) - $signed({1'b0, lo_r.temp});
    prod     = dy * dt;
    prod_abs = prod[16] ? 17'(-prod) : 17'(prod);
    dx_abs   = dx[8] ? 9'(-dx) : 9'(dx);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_mag_r <= prod_abs[PROD_W-1:0];
      prod_neg_r <= prod[16];
      dx_mag_r   <= dx_abs[DX_W-1:0];
      dx_neg_r   <= dx[8];
    end
  end

  fci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_mag_r),
    .den   (dx_mag_r),
    .done  (div_done),
    .quot  (quot)
  );

  // signed quotient plus offset, saturated to the field
  always_comb begin
    q_s = (prod_neg_r ^ dx_neg_r) ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    v   = q_s + $signed({10'd0, lo_r.speed});
    if (v[16]) begin
      v_sat = '0;
    end else if (v > 17'sd127) begin
      v_sat = '1;
    end else begin
      v_sat = v[SPEED_W-1:0];
    end
  end

  always_comb begin
    unique case (cmd.res_sel)
      RES_RDATA: res_nxt = rd_point.speed;
      RES_Y1:    res_nxt = hi_r.speed;
      RES_QUOT:  res_nxt = v_sat;
      default:   res_nxt = rd_point.speed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r <= res_nxt;
    end
    if (cmd.out_load) begin
      out_speed_r <= res_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // status toward the controller
  always_comb begin
    status.none        = (used == '0);
    status.idx_ok      = (32'(point_index) < MAX_POINTS);
    status.t_ge_rd     = (t_r >= rd_point.temp);
    status.t_le_rd     = (t_r <= rd_point.temp);
    status.in_interval = (t_r >= prev_r.temp) && (t_r <= rd_point.temp);
    status.dx_zero     = (dx == 9'sd0);
    status.div_done    = div_done;
    status.out_free    = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign fan_speed  = out_speed_r;

endmodule

// ===== rtl/fci_ctrl.sv =====
// controller state machine: clamps, interval scan, divide and result handoff
`timescale 1ns / 1ps

module fci_ctrl #(
  parameter int MAX_POINTS = fci_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_mode,
  output logic                          in_tready,
  input  logic [$clog2(MAX_POINTS)-1:0] last_addr,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output fci_pkg::ctrl_cmd_t            cmd,
  input  fci_pkg::dp_status_t           status
);
  import fci_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);

  state_t            state_r;
  state_t            state_nxt;
  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W-1:0] cnt_nxt;
  logic [ADDR_W-1:0] cnt_inc;
  logic              is_sample;
  logic              is_load;

  assign cnt_inc   = cnt_r + 1'b1;
  assign is_sample = in_tvalid && (in_mode == MODE_SAMPLE);
  assign is_load   = in_tvalid && (in_mode == MODE_LOAD);

  // state and scan counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (is_sample && !status.none) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = status.t_ge_rd ? S_DONE : S_FIRST;
      end
      S_FIRST: begin
        state_nxt = status.t_le_rd ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (status.in_interval || (cnt_inc == last_addr)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = status.dx_zero ? S_DONE : S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    rd_addr   = '0;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        rd_addr       = last_addr;
        cmd.wr_en     = is_load && status.idx_ok;
        cmd.capture_t = is_sample;
      end
      S_LAST: begin
        rd_addr = '0;
        if (status.t_ge_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RDATA;
        end
      end
      S_FIRST: begin
        rd_addr = ADDR_W'(1);
        cnt_nxt = '0;
        if (status.t_le_rd) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RDATA;
        end else begin
          cmd.load_prev = 1'b1;
        end
      end
      S_SCAN: begin
        rd_addr        = ADDR_W'(cnt_r + 2'd2);
        cmd.save_first = (cnt_r == '0);
        if (status.in_interval) begin
          cmd.set_pair = 1'b1;
          cmd.pair_sel = PAIR_CUR;
        end else if (cnt_inc == last_addr) begin
          // no interval matched: fall back to the first one
          cmd.set_pair = 1'b1;
          cmd.pair_sel = (cnt_r == '0) ? PAIR_CUR : PAIR_SAVED;
        end else begin
          cmd.load_prev = 1'b1;
          cnt_nxt       = cnt_inc;
        end
      end
      S_MUL: begin
        if (status.dx_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_Y1;
        end else begin
          cmd.mul_load = 1'b1;
        end
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_QUOT;
        end
      end
      S_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide wait");

  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && state_nxt == S_SCAN) |=> cnt_r == ADDR_W'($past(cnt_r) + 1'b1))
    else $error("scan counter skipped an interval");

  a_res_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> state_r == S_DONE)
    else $error("result computed without handoff");

endmodule

// ===== rtl/fan_curve_interpolator.sv =====
// fan curve interpolator top level
//
// Maps temperature samples to fan speed percent on a piecewise linear curve.
// Input stream in_*: in_tuser selects the request kind (0 load point,
// 1 temperature sample). A load request writes one curve slot and gives no
// result; a sample gives one fan_speed on out_* unless no points are in use.
// cfg_* writes points_in_use; it is always ready. The user must write it
// only while idle; the block does not enforce this. One request is worked
// on at a time, in_tready is high only when idle. A load request ends in
// S_IDLE. A sample passes S_LAST; if not clamped there, S_FIRST; if not
// clamped there, the memory scan in S_SCAN, one point per cycle over at most
// MAX_POINTS - 1 intervals, then S_MUL and, unless the interval is flat,
// S_DIVGO and the bit-serial divider in S_DIV. A finished result sits in an
// output register; the next request is taken while it waits, and a further
// result waits until it is taken. Reset clears points_in_use and the
// handshakes; curve slots hold whatever they held until written.
`timescale 1ns / 1ps

module fan_curve_interpolator #(
  parameter int MAX_POINTS = fci_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // point_index[3:0], point_temp[11:4], point_speed[18:12], sample_temp[26:19]
  input  logic [fci_pkg::IN_TDATA_W-1:0]     in_tdata,
  // mode[0]
  input  logic                               in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // fan_speed[6:0]
  output logic [fci_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // points_in_use write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fci_pkg::PIU_W-1:0]          cfg_data
);
  import fci_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  last_addr;
  logic [SPEED_W-1:0] fan_speed;

  assign cfg_ready = 1'b1;

  fci_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .last_addr (last_addr),
    .rd_addr   (rd_addr),
    .cmd       (cmd),
    .status    (status)
  );

  fci_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .point_index (in_tdata[3:0]),
    .point_temp  (in_tdata[11:4]),
    .point_speed (in_tdata[18:12]),
    .sample_temp (in_tdata[26:19]),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .last_addr   (last_addr),
    .status      (status),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .fan_speed   (fan_speed)
  );

  assign out_tdata = {1'b0, fan_speed};

endmodule
